// File: src/fim_pkg.sv
// ----------------------------------------------------------------------------
// fim_pkg
// Shared widths, constants and modular arithmetic for the Fletcher-32
// integrity monitor.
// ----------------------------------------------------------------------------
package fim_pkg;

   localparam int BYTE_W  = 8;
   localparam int HALF_W  = 16;
   localparam int WORD_W  = 32;

   localparam logic [HALF_W-1:0] FLETCHER_MOD = 16'hffff;

   // a is at most 65534, b at most 65535; result lies in 0..65534
   function automatic logic [HALF_W-1:0] mod_add(input logic [HALF_W-1:0] a,
                                                 input logic [HALF_W-1:0] b);
      logic [HALF_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, FLETCHER_MOD}) begin
         s = s - {1'b0, FLETCHER_MOD};
      end
      return s[HALF_W-1:0];
   endfunction

endpackage

// File: src/fletcher32_integrity_monitor_top.sv
// ----------------------------------------------------------------------------
// fletcher32_integrity_monitor_top
// Byte-stream Fletcher-32 and byte-sum monitor with capture and verify modes.
// ----------------------------------------------------------------------------
// Accepts one byte per cycle. Each accepted transaction is held in an input
// register and folded into the running sums from there by one pass of
// short modular adds; the transaction flagged as the final byte of a region
// passes from the input register into the result register, which offers its
// result. The result register decouples the sides: input keeps flowing
// while a result waits, and stalls only when a result is held and a new one
// is ready to replace it. Write csr_verify_mode only while the block is idle.
module fletcher32_integrity_monitor_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [fim_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic                        req_last_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [fim_pkg::WORD_W-1:0]  rsp_checksum,
   output logic [fim_pkg::WORD_W-1:0]  rsp_byte_total,
   output logic                        rsp_checksum_mismatch,
   output logic                        rsp_total_mismatch,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_verify_mode
);

   logic                        verify_mode_ff, verify_mode_in;
   logic                        in_valid_ff, in_valid_in;
   logic [fim_pkg::BYTE_W-1:0]  in_byte_ff, in_byte_in;
   logic                        in_last_ff, in_last_in;

   logic [fim_pkg::HALF_W-1:0]  first_sum_ff, first_sum_in;
   logic [fim_pkg::HALF_W-1:0]  second_sum_ff, second_sum_in;
   logic [fim_pkg::BYTE_W-1:0]  held_byte_ff, held_byte_in;
   logic                        held_ff, held_in;
   logic [fim_pkg::WORD_W-1:0]  total_ff, total_in;
   logic [fim_pkg::WORD_W-1:0]  ref_checksum_ff, ref_checksum_in;
   logic [fim_pkg::WORD_W-1:0]  ref_total_ff, ref_total_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [fim_pkg::WORD_W-1:0]  rsp_checksum_ff, rsp_checksum_in;
   logic [fim_pkg::WORD_W-1:0]  rsp_total_ff, rsp_total_in;
   logic                        rsp_cks_mis_ff, rsp_cks_mis_in;
   logic                        rsp_tot_mis_ff, rsp_tot_mis_in;

   logic                        advance;
   logic                        process;
   logic                        add_word;
   logic [fim_pkg::HALF_W-1:0]  word;
   logic [fim_pkg::HALF_W-1:0]  new_first;
   logic [fim_pkg::HALF_W-1:0]  new_second;
   logic [fim_pkg::WORD_W-1:0]  new_total;
   logic [fim_pkg::WORD_W-1:0]  cks;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign process   = in_valid_ff && (!in_last_ff || advance);
   assign req_ready = !in_valid_ff || process;
   assign csr_ready = 1'b1;

   assign add_word   = held_ff || in_last_ff;
   assign word       = held_ff ? {in_byte_ff, held_byte_ff}
                               : {{(fim_pkg::HALF_W-fim_pkg::BYTE_W){1'b0}}, in_byte_ff};
   assign new_first  = fim_pkg::mod_add(first_sum_ff, word);
   assign new_second = fim_pkg::mod_add(second_sum_ff, new_first);
   assign new_total  = total_ff + {{(fim_pkg::WORD_W-fim_pkg::BYTE_W){1'b0}}, in_byte_ff};
   assign cks        = add_word ? {new_second, new_first} : {second_sum_ff, first_sum_ff};

   always_comb begin
      verify_mode_in  = (csr_valid && csr_ready) ? csr_verify_mode : verify_mode_ff;

      in_valid_in     = (req_valid && req_ready) ? 1'b1 : (process ? 1'b0 : in_valid_ff);
      in_byte_in      = (req_valid && req_ready) ? req_data_byte : in_byte_ff;
      in_last_in      = (req_valid && req_ready) ? req_last_byte : in_last_ff;

      first_sum_in    = first_sum_ff;
      second_sum_in   = second_sum_ff;
      held_byte_in    = held_byte_ff;
      held_in         = held_ff;
      total_in        = total_ff;
      ref_checksum_in = ref_checksum_ff;
      ref_total_in    = ref_total_ff;

      rsp_valid_in    = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_checksum_in = rsp_checksum_ff;
      rsp_total_in    = rsp_total_ff;
      rsp_cks_mis_in  = rsp_cks_mis_ff;
      rsp_tot_mis_in  = rsp_tot_mis_ff;

      if (process) begin
         if (in_last_ff) begin
            first_sum_in    = '0;
            second_sum_in   = '0;
            held_in         = 1'b0;
            total_in        = '0;
            rsp_valid_in    = 1'b1;
            rsp_checksum_in = cks;
            rsp_total_in    = new_total;
            if (verify_mode_ff) begin
               rsp_cks_mis_in = (cks != ref_checksum_ff);
               rsp_tot_mis_in = (new_total != ref_total_ff);
            end else begin
               rsp_cks_mis_in  = 1'b0;
               rsp_tot_mis_in  = 1'b0;
               ref_checksum_in = cks;
               ref_total_in    = new_total;
            end
         end else begin
            total_in = new_total;
            if (held_ff) begin
               first_sum_in  = new_first;
               second_sum_in = new_second;
               held_in       = 1'b0;
            end else begin
               held_byte_in = in_byte_ff;
               held_in      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         verify_mode_ff  <= 1'b0;
         in_valid_ff     <= 1'b0;
         first_sum_ff    <= '0;
         second_sum_ff   <= '0;
         held_byte_ff    <= '0;
         held_ff         <= 1'b0;
         total_ff        <= '0;
         ref_checksum_ff <= '0;
         ref_total_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         verify_mode_ff  <= verify_mode_in;
         in_valid_ff     <= in_valid_in;
         first_sum_ff    <= first_sum_in;
         second_sum_ff   <= second_sum_in;
         held_byte_ff    <= held_byte_in;
         held_ff         <= held_in;
         total_ff        <= total_in;
         ref_checksum_ff <= ref_checksum_in;
         ref_total_ff    <= ref_total_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff      <= in_byte_in;
      in_last_ff      <= in_last_in;
      rsp_checksum_ff <= rsp_checksum_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_cks_mis_ff  <= rsp_cks_mis_in;
      rsp_tot_mis_ff  <= rsp_tot_mis_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_checksum          = rsp_checksum_ff;
   assign rsp_byte_total        = rsp_total_ff;
   assign rsp_checksum_mismatch = rsp_cks_mis_ff;
   assign rsp_total_mismatch    = rsp_tot_mis_ff;

endmodule

// File: src/fim_checker.sv
// ----------------------------------------------------------------------------
// fim_checker
// Port-level checks for the Fletcher-32 integrity monitor.
// ----------------------------------------------------------------------------
module fim_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [fim_pkg::WORD_W-1:0]  rsp_checksum,
   input logic [fim_pkg::WORD_W-1:0]  rsp_byte_total
);

   // hold a stalled result transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_checksum)
                                 && $stable(rsp_byte_total))
      else $error("stalled result transaction changed");

   // both Fletcher halves stay below the modulus
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_checksum[15:0] != fim_pkg::FLETCHER_MOD)
                 && (rsp_checksum[31:16] != fim_pkg::FLETCHER_MOD))
      else $error("checksum half not reduced");

   // an empty result register never blocks input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with result register empty");

   // no result straight out of reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind fletcher32_integrity_monitor_top fim_checker u_fim_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_checksum   (rsp_checksum),
   .rsp_byte_total (rsp_byte_total)
);
